// ----- sv/mieu_pkg.sv -----
// mieu_pkg: opcodes, status codes, state encoding and constants for the
// integer execute unit. No dependencies.
package mieu_pkg;

    localparam int unsigned XLEN     = 32;
    localparam int unsigned REG_AW   = 5;
    localparam int unsigned REG_N    = 32;
    localparam logic [4:0]  LINK_REG = 5'd31;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADDI  = 5'd1,
        OP_ADDIU = 5'd2,
        OP_ADDU  = 5'd3,
        OP_AND   = 5'd4,
        OP_ANDI  = 5'd5,
        OP_BEQ   = 5'd6,
        OP_BGEZ  = 5'd7,
        OP_BGTZ  = 5'd8,
        OP_BLEZ  = 5'd9,
        OP_BLTZ  = 5'd10,
        OP_BNE   = 5'd11,
        OP_BREAK = 5'd12,
        OP_DIV   = 5'd13,
        OP_J     = 5'd14,
        OP_JAL   = 5'd15,
        OP_JALR  = 5'd16,
        OP_JR    = 5'd17
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OVF   = 3'd1,
        ST_BRK   = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_UNDEF = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DIVFIX,
        S_OUT
    } fsm_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// ----- sv/mieu_ram.sv -----
// mieu_ram: generic single-port-write, dual-read synchronous RAM with
// registered read data. No dependencies.
module mieu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

// ----- sv/mips_integer_execute_unit_top.sv -----
// mips_integer_execute_unit_top: mips32 integer/branch execute unit with
// the register file in mieu_ram. Depends on mieu_pkg and mieu_ram.
//
// One instruction is a transaction on the input channel and produces one
// result transaction. After reset the unit zeroes every register of the
// register file before it accepts anything. An instruction then passes
// through register file read, execute with write-back and result held,
// except DIV with a nonzero divisor, which adds a one-bit-per-cycle
// restoring divider plus a sign fixup step. The register file has a
// single write port and a registered read; the next instruction is
// accepted once the result has been taken or while it is taken.
module mips_integer_execute_unit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  action,
    input  logic [4:0]  src_reg,
    input  logic [4:0]  second_reg,
    input  logic [4:0]  dest_reg,
    input  logic [15:0] imm_field,
    input  logic [25:0] jump_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        jump_valid,
    output logic [31:0] jump_address,
    output logic [31:0] pc_after,
    output logic        wrote_reg,
    output logic [4:0]  write_index,
    output logic [31:0] write_value
);
    import mieu_pkg::*;

    fsm_t state_reg, state_next;

    logic [4:0]  op_reg;
    logic [4:0]  rs_reg, rt_reg, rd_reg;
    logic [15:0] imm_reg;
    logic [25:0] idx_reg;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [31:0] a_reg, a_next;    // divider remainder
    logic [31:0] q_reg, q_next;    // dividend magnitude shifting into quotient
    logic [31:0] mb_reg, mb_next;
    logic        sa_reg, sb_reg;

    logic [2:0]  st_reg, st_next;
    logic        jv_reg, jv_next;
    logic [31:0] ja_reg, ja_next;
    logic [31:0] pa_reg, pa_next;
    logic        wr_reg, wr_next;
    logic [4:0]  wi_reg, wi_next;
    logic [31:0] wv_reg, wv_next;

    logic        ram_we;
    logic [4:0]  ram_waddr;
    logic [31:0] ram_wdata, rdata_a, rdata_b;

    logic        acc_in;
    assign acc_in = in_valid && !in_stall;

    mieu_ram #(.WIDTH(XLEN), .DEPTH(REG_N)) u_regs (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (rs_reg),
        .raddr_b (rt_reg),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (cnt_reg == 6'd31) state_next = S_IDLE;
            S_IDLE:   if (acc_in) state_next = S_READ;
            S_READ:   state_next = S_EXEC;
            S_EXEC:   state_next = (op_reg == OP_DIV && rdata_b != 32'd0) ? S_DIV : S_OUT;
            S_DIV:    if (cnt_reg == 6'd31) state_next = S_DIVFIX;
            S_DIVFIX: state_next = S_OUT;
            S_OUT:    if (!out_stall) state_next = acc_in ? S_READ : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath
    logic [31:0] a, b, pc4, sum, bsel, tgt, simm;
    logic        take, wr, ovf;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic [32:0] trial;
    logic [31:0] rem_sh;

    always_comb
    begin
        a = rdata_a;
        b = rdata_b;
        pc4 = pc_reg + 32'd4;
        simm = sext16(imm_reg);
        bsel = (op_reg == OP_ADD) ? b : simm;
        sum = a + bsel;
        ovf = (a[31] == bsel[31]) && (sum[31] != a[31]);
        take = 1'b0;
        wr = 1'b0;
        widx = 5'd0;
        wval = 32'd0;
        tgt = 32'd0;
        st_next = st_reg;
        jv_next = jv_reg;
        ja_next = ja_reg;
        pa_next = pa_reg;
        wr_next = wr_reg;
        wi_next = wi_reg;
        wv_next = wv_reg;
        pc_next = pc_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        a_next = a_reg;
        q_next = q_reg;
        mb_next = mb_reg;
        cnt_next = cnt_reg;
        ram_we = 1'b0;
        ram_waddr = cnt_reg[4:0];
        ram_wdata = 32'd0;
        rem_sh = {a_reg[30:0], q_reg[31]};
        trial = {1'b0, rem_sh} - {1'b0, mb_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                cnt_next = cnt_reg + 6'd1;
            end
            S_EXEC:
            begin
                st_next = ST_OK;
                jv_next = 1'b0;
                ja_next = 32'd0;
                unique case (op_reg)
                    OP_ADD, OP_ADDI:
                    begin
                        if (ovf) st_next = ST_OVF;
                        else
                        begin
                            wr = 1'b1;
                            widx = (op_reg == OP_ADD) ? rd_reg : rt_reg;
                            wval = sum;
                        end
                    end
                    OP_ADDIU: begin wr = 1'b1; widx = rt_reg; wval = a + simm; end
                    OP_ADDU:  begin wr = 1'b1; widx = rd_reg; wval = a + b; end
                    OP_AND:   begin wr = 1'b1; widx = rd_reg; wval = a & b; end
                    OP_ANDI:  begin wr = 1'b1; widx = rt_reg; wval = a & {16'd0, imm_reg}; end
                    OP_BEQ:   take = (a == b);
                    OP_BGEZ:  take = !a[31];
                    OP_BGTZ:  take = !a[31] && (a != 32'd0);
                    OP_BLEZ:  take = a[31] || (a == 32'd0);
                    OP_BLTZ:  take = a[31];
                    OP_BNE:   take = (a != b);
                    OP_BREAK: st_next = ST_BRK;
                    OP_DIV:
                    begin
                        if (b == 32'd0) st_next = ST_DIVZ;
                        a_next = 32'd0;
                        q_next = a[31] ? (32'd0 - a) : a;
                        mb_next = b[31] ? (32'd0 - b) : b;
                        cnt_next = 6'd0;
                    end
                    OP_J, OP_JAL:
                    begin
                        jv_next = 1'b1;
                        tgt = {pc4[31:28], idx_reg, 2'b00};
                        ja_next = tgt;
                        if (op_reg == OP_JAL)
                        begin
                            wr = 1'b1; widx = LINK_REG; wval = pc_reg + 32'd8;
                        end
                    end
                    OP_JALR:
                    begin
                        jv_next = 1'b1; tgt = a; ja_next = a;
                        wr = 1'b1; widx = rd_reg; wval = pc_reg + 32'd8;
                    end
                    OP_JR:    begin jv_next = 1'b1; tgt = a; ja_next = a; end
                    default:  st_next = ST_UNDEF;
                endcase
                if (wr && widx == 5'd0)
                begin
                    wr = 1'b0; wval = 32'd0;
                end
                pc_next = jv_next ? tgt : (take ? pc4 + {simm[29:0], 2'b00} : pc4);
                pa_next = pc_next;
                wr_next = wr;
                wi_next = widx;
                wv_next = wval;
                ram_we = wr;
                ram_waddr = widx;
                ram_wdata = wval;
            end
            S_DIV:
            begin
                q_next = {q_reg[30:0], !trial[32]};
                a_next = trial[32] ? rem_sh : trial[31:0];
                cnt_next = cnt_reg + 6'd1;
            end
            S_DIVFIX:
            begin
                lo_next = (sa_reg != sb_reg) ? (32'd0 - q_reg) : q_reg;
                hi_next = sa_reg ? (32'd0 - a_reg) : a_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= 6'd0;
            pc_reg    <= 32'd0;
            hi_reg    <= 32'd0;
            lo_reg    <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pc_reg    <= pc_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            op_reg  <= action;
            rs_reg  <= src_reg;
            rt_reg  <= second_reg;
            rd_reg  <= dest_reg;
            imm_reg <= imm_field;
            idx_reg <= jump_index;
        end
        if (state_reg == S_EXEC)
        begin
            sa_reg <= rdata_a[31];
            sb_reg <= rdata_b[31];
        end
        a_reg  <= a_next;
        q_reg  <= q_next;
        mb_reg <= mb_next;
        st_reg <= st_next;
        jv_reg <= jv_next;
        ja_reg <= ja_next;
        pa_reg <= pa_next;
        wr_reg <= wr_next;
        wi_reg <= wi_next;
        wv_reg <= wv_next;
    end

    // outputs
    always_comb
    begin
        in_stall     = !(state_reg == S_IDLE || (state_reg == S_OUT && !out_stall));
        out_valid    = (state_reg == S_OUT);
        status       = st_reg;
        jump_valid   = jv_reg;
        jump_address = ja_reg;
        pc_after     = pa_reg;
        wrote_reg    = wr_reg;
        write_index  = wi_reg;
        write_value  = wv_reg;
    end

    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(wrote_reg && write_index == 5'd0))
        else $error("write to r0 reported");
    a_no_wr_on_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVF) |-> !wrote_reg)
        else $error("overflow with write");
    a_jump_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && jump_valid) |-> (pc_after == jump_address))
        else $error("jump pc mismatch");
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("accept during clear");
endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for mips_integer_execute_unit_top, with a scoreboard
// class that predicts each result. Depends on mieu_pkg and the unit's rtl.
module tb;
    import mieu_pkg::*;

    typedef struct packed {
        logic [4:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [15:0] imm;
        logic [25:0] idx;
    } instr_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        jv;
        logic [31:0] jaddr;
        logic [31:0] pc;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
    } exec_result_t;

    class exec_scoreboard;
        logic [31:0]  regs [32];
        logic [31:0]  hi_q;
        logic [31:0]  lo_q;
        logic [31:0]  pc_q;
        exec_result_t pending_q [$];
        int           failures;

        function new();
            for (int i = 0; i < 32; i++)
                regs[i] = '0;
            hi_q = '0;
            lo_q = '0;
            pc_q = '0;
            failures = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // executes one accepted instruction on the shadow state
        function void note_instr(instr_t ins);
            logic [31:0] a, b, simm, pc4, sum, opnd, ma, mb, q, r;
            logic        take;
            exec_result_t e;
            a = regs[ins.rs];
            b = regs[ins.rt];
            simm = {{16{ins.imm[15]}}, ins.imm};
            pc4 = pc_q + 32'd4;
            take = 1'b0;
            e = '0;
            e.status = ST_OK;
            case (ins.op)
                OP_ADD, OP_ADDI:
                begin
                    opnd = (ins.op == OP_ADD) ? b : simm;
                    sum = a + opnd;
                    if (a[31] == opnd[31] && sum[31] != a[31])
                        e.status = ST_OVF;
                    else
                    begin
                        e.wr = 1'b1;
                        e.widx = (ins.op == OP_ADD) ? ins.rd : ins.rt;
                        e.wval = sum;
                    end
                end
                OP_ADDIU:
                begin
                    e.wr = 1'b1; e.widx = ins.rt; e.wval = a + simm;
                end
                OP_ADDU:
                begin
                    e.wr = 1'b1; e.widx = ins.rd; e.wval = a + b;
                end
                OP_AND:
                begin
                    e.wr = 1'b1; e.widx = ins.rd; e.wval = a & b;
                end
                OP_ANDI:
                begin
                    e.wr = 1'b1; e.widx = ins.rt; e.wval = a & {16'h0, ins.imm};
                end
                OP_BEQ:  take = (a == b);
                OP_BGEZ: take = !a[31];
                OP_BGTZ: take = !a[31] && a != 0;
                OP_BLEZ: take = a[31] || a == 0;
                OP_BLTZ: take = a[31];
                OP_BNE:  take = (a != b);
                OP_BREAK: e.status = ST_BRK;
                OP_DIV:
                begin
                    if (b == 0)
                        e.status = ST_DIVZ;
                    else
                    begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        r = ma % mb;
                        if (a[31] != b[31])
                            q = -q;
                        if (a[31])
                            r = -r;
                        lo_q = q;
                        hi_q = r;
                    end
                end
                OP_J, OP_JAL:
                begin
                    e.jv = 1'b1;
                    e.jaddr = (pc4 & 32'hF000_0000) | {4'h0, ins.idx, 2'b00};
                    if (ins.op == OP_JAL)
                    begin
                        e.wr = 1'b1; e.widx = LINK_REG; e.wval = pc_q + 32'd8;
                    end
                end
                OP_JALR:
                begin
                    e.jv = 1'b1; e.jaddr = a;
                    e.wr = 1'b1; e.widx = ins.rd; e.wval = pc_q + 32'd8;
                end
                OP_JR:
                begin
                    e.jv = 1'b1; e.jaddr = a;
                end
                default: e.status = ST_UNDEF;
            endcase
            e.pc = pc4;
            if (take)
                e.pc = pc4 + {simm[29:0], 2'b00};
            if (e.jv)
                e.pc = e.jaddr;
            // writes to r0 are dropped entirely
            if (e.wr && e.widx == 0)
            begin
                e.wr = 1'b0; e.widx = '0; e.wval = '0;
            end
            if (e.wr)
                regs[e.widx] = e.wval;
            pc_q = e.pc;
            pending_q.push_back(e);
        endfunction

        function void check_result(exec_result_t got);
            exec_result_t e;
            if (pending_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result transaction: %p", got);
                return;
            end
            e = pending_q.pop_front();
            if (got !== e)
            begin
                failures++;
                if (failures <= 10)
                    $display("result mismatch: expected %p, actual %p", e, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [4:0]  action;
    logic [4:0]  src_reg;
    logic [4:0]  second_reg;
    logic [4:0]  dest_reg;
    logic [15:0] imm_field;
    logic [25:0] jump_index;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic        jump_valid;
    logic [31:0] jump_address;
    logic [31:0] pc_after;
    logic        wrote_reg;
    logic [4:0]  write_index;
    logic [31:0] write_value;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TARGET_ITEMS = 1550;

    exec_scoreboard sb;
    int             cycles;
    int             sent;
    int             stall_left;
    bit             drained;

    mips_integer_execute_unit_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .src_reg      (src_reg),
        .second_reg   (second_reg),
        .dest_reg     (dest_reg),
        .imm_field    (imm_field),
        .jump_index   (jump_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .jump_valid   (jump_valid),
        .jump_address (jump_address),
        .pc_after     (pc_after),
        .wrote_reg    (wrote_reg),
        .write_index  (write_index),
        .write_value  (write_value)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver: random stall pattern, with stall-free stretches
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_left <= pick_gap() + 1;
        end
        else
            stall_left <= stall_left - 1;
    end

    always @(posedge clk)
    begin
        exec_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, jump_valid, jump_address, pc_after,
                   wrote_reg, write_index, write_value};
            sb.check_result(got);
        end
    end

    task automatic send_instr(instr_t ins);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action     <= ins.op;
        src_reg    <= ins.rs;
        second_reg <= ins.rt;
        dest_reg   <= ins.rd;
        imm_field  <= ins.imm;
        jump_index <= ins.idx;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_instr(ins);
        sent++;
    endtask

    task automatic send_op(logic [4:0] op, logic [4:0] rs, logic [4:0] rt,
                           logic [4:0] rd, logic [15:0] imm);
        instr_t ins;
        ins.op = op; ins.rs = rs; ins.rt = rt; ins.rd = rd;
        ins.imm = imm; ins.idx = 26'($urandom_range(0, 26'h3FF_FFFF));
        send_instr(ins);
    endtask

    // builds 0x80000000 in rmin, -1 in rneg and 0x7fffffff in rmax
    task automatic build_extremes(logic [4:0] rmin, logic [4:0] rneg, logic [4:0] rmax);
        send_op(OP_ADDIU, 5'd0, rmin, 5'd0, 16'h8000);
        repeat (16) send_op(OP_ADDU, rmin, rmin, rmin, 16'h0);
        send_op(OP_ADDIU, 5'd0, rneg, 5'd0, 16'hFFFF);
        send_op(OP_ADDU, rmin, rneg, rmax, 16'h0);
    endtask

    function automatic instr_t random_instr();
        instr_t ins;
        int     r;
        ins.op  = 5'($urandom_range(0, 17));
        if ($urandom_range(0, 19) == 0)
            ins.op = 5'($urandom_range(18, 31));
        ins.rs  = 5'($urandom_range(0, 31));
        ins.rt  = 5'($urandom_range(0, 31));
        ins.rd  = 5'($urandom_range(0, 31));
        ins.idx = 26'($urandom_range(0, 26'h3FF_FFFF));
        r = $urandom_range(0, 9);
        case (r)
            0: ins.imm = 16'h0000;
            1: ins.imm = 16'hFFFF;
            2: ins.imm = 16'h7FFF;
            3: ins.imm = 16'h8000;
            default: ins.imm = 16'($urandom_range(0, 16'hFFFF));
        endcase
        return ins;
    endfunction

    initial
    begin
        instr_t ins;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = '0;
        src_reg = '0;
        second_reg = '0;
        dest_reg = '0;
        imm_field = '0;
        jump_index = '0;
        out_stall = 1'b0;
        cycles = 0;
        sent = 0;
        stall_left = 0;
        drained = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: r1 = most negative, r2 = -1, r3 = most positive
        build_extremes(5'd1, 5'd2, 5'd3);
        send_op(OP_DIV, 5'd1, 5'd2, 5'd0, 16'h0);
        send_op(OP_DIV, 5'd1, 5'd0, 5'd0, 16'h0);
        send_op(OP_ADD, 5'd1, 5'd2, 5'd4, 16'h0);
        send_op(OP_ADDI, 5'd3, 5'd5, 5'd0, 16'h0001);
        send_op(OP_BREAK, 5'd0, 5'd0, 5'd0, 16'h0);
        send_op(5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF);
        send_op(OP_JALR, 5'd3, 5'd0, 5'd0, 16'h0);
        send_op(OP_JAL, 5'd0, 5'd0, 5'd0, 16'h0);
        send_op(OP_JR, 5'd31, 5'd0, 5'd0, 16'h0);

        while (sent < TARGET_ITEMS)
        begin
            if (!drained && sent >= 800)
            begin
                // let the unit drain completely once
                drained = 1'b1;
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 24) == 0)
                build_extremes(5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)),
                               5'($urandom_range(1, 31)));
            else
            begin
                ins = random_instr();
                send_instr(ins);
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.failures == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
